/* hdl/fhu_pkg.sv */
// shared types, constants and helpers of the flocking heading update unit
// no dependencies; imported by fhu_cordic_step and flocking_heading_update_unit
package fhu_pkg;

  localparam int POS_W   = 16;
  localparam int VEL_W   = 16;
  localparam int SUM_W   = 25;
  localparam int CNT_OW  = 9;
  localparam int CFG_W   = 16;
  localparam int CFG_IW  = 3;

  // shift-add datapath width, wide enough for speed times the cordic growth
  localparam int DP_W    = 34;
  localparam int ATAN_N  = 24;
  localparam int STEP_W  = 5;

  localparam int MUL_AW  = 18;
  localparam int MUL_BW  = 31;
  localparam int PROD_W  = MUL_AW + MUL_BW;

  // inverse cordic gain, 2^30 / 1.6468
  localparam logic signed [MUL_BW-1:0] GAIN_INV = 31'sd652032874;
  localparam logic signed [DP_W-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [DP_W-1:0] HALF_TURN    = 34'sd2147483648;

  localparam logic [CFG_IW-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SPEED  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_GAIN   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic              vectoring;
    logic [STEP_W-1:0] step;
  } cordic_ctl_t;

  // atan(2^-i), half turn = 2^31
  function automatic logic [31:0] atan_angle(input logic [STEP_W-1:0] i);
    case (i)
      5'd0:  atan_angle = 32'h20000000;
      5'd1:  atan_angle = 32'h12E4051E;
      5'd2:  atan_angle = 32'h09FB385B;
      5'd3:  atan_angle = 32'h051111D4;
      5'd4:  atan_angle = 32'h028B0D43;
      5'd5:  atan_angle = 32'h0145D7E1;
      5'd6:  atan_angle = 32'h00A2F61E;
      5'd7:  atan_angle = 32'h00517C55;
      5'd8:  atan_angle = 32'h0028BE53;
      5'd9:  atan_angle = 32'h00145F2F;
      5'd10: atan_angle = 32'h000A2F98;
      5'd11: atan_angle = 32'h000517CC;
      5'd12: atan_angle = 32'h00028BE6;
      5'd13: atan_angle = 32'h000145F3;
      5'd14: atan_angle = 32'h0000A2F9;
      5'd15: atan_angle = 32'h0000517C;
      5'd16: atan_angle = 32'h000028BE;
      5'd17: atan_angle = 32'h0000145F;
      5'd18: atan_angle = 32'h00000A2F;
      5'd19: atan_angle = 32'h00000517;
      5'd20: atan_angle = 32'h0000028B;
      5'd21: atan_angle = 32'h00000145;
      5'd22: atan_angle = 32'h000000A2;
      5'd23: atan_angle = 32'h00000051;
      default: atan_angle = 32'h00000000;
    endcase
  endfunction

  // round, shift down sixteen, optional negate, clamp to 16 bits
  function automatic logic signed [VEL_W-1:0] round_sat(input logic signed [DP_W-1:0] v,
                                                         input logic flip);
    logic signed [DP_W-1:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (flip) r = -r;
    if (r > 34'sd32767) round_sat = 16'sh7FFF;
    else if (r < -34'sd32768) round_sat = 16'sh8000;
    else round_sat = r[VEL_W-1:0];
  endfunction

  // move one axis by a Q3.12 velocity and wrap to 0 or the bound
  function automatic logic [POS_W-1:0] move_wrap(input logic [POS_W-1:0] p,
                                                 input logic signed [VEL_W-1:0] v,
                                                 input logic [POS_W-1:0] bound);
    logic signed [16:0] vr;
    logic signed [18:0] q;
    logic signed [18:0] b;
    vr = 17'(v) + 17'sd32;
    q  = 19'(signed'({1'b0, p})) + 19'(vr >>> 6);
    b  = signed'({3'b000, bound});
    if (q > b) move_wrap = '0;
    else if (q < 19'sd0) move_wrap = bound;
    else move_wrap = q[POS_W-1:0];
  endfunction

endpackage

/* hdl/flocking_heading_update_unit.sv */
// top level of the flocking heading update: distance test, velocity sums,
// atan2 and polar conversion on one shared cordic step and one shared multiplier
// depends on fhu_pkg and fhu_cordic_step
//
//  channel   dir  handshake                       content
//  s_axis    in   s_axis_tvalid / s_axis_tready   one candidate neighbour per beat
//  m_axis    out  m_axis_tvalid / m_axis_tready   one updated particle per run
//  cfg       in   cfg_we                          register index and data
//
//  a candidate that is not last passes S_DX, S_DY, S_R2 and S_ACC before the next acceptance
//  the last candidate then runs S_NOISE, S_VEC, S_HEAD, S_LROT, S_ROT, S_FIN and S_OUT, with
//  vectoring then rotation iterated CORDIC_STEPS capped at 24 times on the single cordic step unit
//  the input waits in S_OUT while the result register is still held by m_axis_tready low
//  rst clears the sequencer, the sums, the count and loads the register defaults
module flocking_heading_update_unit #(
  parameter int MAX_NEIGHBOURS = 256,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // self_x, self_y, cand_x, cand_y, cand_vx, cand_vy, noise_sample
  input  logic [111:0]                  s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // new_x, new_y, new_vx, new_vy, new_heading, neighbour_count, zero pad
  output logic [95:0]                   m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [fhu_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [fhu_pkg::CFG_W-1:0]     cfg_data
);
  import fhu_pkg::*;

  localparam int STEPS_USED = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;
  localparam int CW  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int CXW = (CW > CNT_OW) ? CW : CNT_OW;

  typedef enum logic [3:0] {
    S_IDLE, S_DX, S_DY, S_R2, S_ACC, S_NOISE, S_VEC, S_HEAD, S_LROT, S_ROT, S_FIN, S_OUT
  } state_t;

  state_t state;

  logic [POS_W-1:0]  radius;
  logic [14:0]       speed;
  logic [15:0]       gain;
  logic [POS_W-1:0]  arena_w;
  logic [POS_W-1:0]  arena_h;

  logic [POS_W-1:0]        self_x;
  logic [POS_W-1:0]        self_y;
  logic signed [16:0]      dx;
  logic signed [16:0]      dy;
  logic signed [VEL_W-1:0] cvx;
  logic signed [VEL_W-1:0] cvy;
  logic signed [15:0]      noise;
  logic                    last;

  logic signed [SUM_W-1:0] sum_vx;
  logic signed [SUM_W-1:0] sum_vy;
  logic [CW-1:0]           count;
  logic [CNT_OW-1:0]       count_out;
  logic [32:0]             d2;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [DP_W-1:0] cx;
  logic signed [DP_W-1:0] cy;
  logic signed [DP_W-1:0] cz;
  logic signed [DP_W-1:0] nx;
  logic signed [DP_W-1:0] ny;
  logic signed [DP_W-1:0] nz;
  cordic_ctl_t            ctl;
  logic [STEP_W-1:0]      step;
  logic                   zero_sum;
  logic                   flip;

  logic signed [15:0]      heading;
  logic signed [VEL_W-1:0] vx;
  logic signed [VEL_W-1:0] vy;

  logic signed [SUM_W:0]   sx_add;
  logic signed [SUM_W:0]   sy_add;
  logic signed [DP_W-1:0]  sxe;
  logic signed [DP_W-1:0]  sye;
  logic [31:0]             z_round;
  logic [15:0]             head_vec;
  logic signed [DP_W-1:0]  zh;
  logic [CXW-1:0]          count_ext;

  assign s_axis_tready = (state == S_IDLE);

  assign ctl.vectoring = (state == S_VEC);
  assign ctl.step      = step;

  fhu_cordic_step u_step (
    .ctl (ctl),
    .x   (cx),
    .y   (cy),
    .z   (cz),
    .nx  (nx),
    .ny  (ny),
    .nz  (nz)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DX: begin
        mul_a = MUL_AW'(dx);
        mul_b = MUL_BW'(dx);
      end
      S_DY: begin
        mul_a = MUL_AW'(dy);
        mul_b = MUL_BW'(dy);
      end
      S_R2: begin
        mul_a = {2'b00, radius};
        mul_b = {15'd0, radius};
      end
      S_NOISE: begin
        mul_a = MUL_AW'(noise);
        mul_b = {15'd0, gain};
      end
      S_HEAD: begin
        mul_a = {3'b000, speed};
        mul_b = GAIN_INV;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sx_add    = (SUM_W+1)'(sum_vx) + (SUM_W+1)'(cvx);
  assign sy_add    = (SUM_W+1)'(sum_vy) + (SUM_W+1)'(cvy);
  assign sxe       = DP_W'(sum_vx);
  assign sye       = DP_W'(sum_vy);
  assign z_round   = cz[31:0] + 32'h0000_8000;
  assign head_vec  = zero_sum ? 16'd0 : z_round[31:16];
  assign zh        = {{2{heading[15]}}, heading, 16'd0};
  assign count_ext = CXW'(count);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius  <= 16'd640;
      speed   <= 15'd8192;
      gain    <= 16'd7301;
      arena_w <= 16'd57600;
      arena_h <= 16'd57600;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS: radius  <= cfg_data;
        REG_SPEED:  speed   <= cfg_data[14:0];
        REG_GAIN:   gain    <= cfg_data;
        REG_WIDTH:  arena_w <= cfg_data;
        REG_HEIGHT: arena_h <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      sum_vx        <= '0;
      sum_vy        <= '0;
      count         <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            self_x <= s_axis_tdata[15:0];
            self_y <= s_axis_tdata[31:16];
            dx     <= signed'({1'b0, s_axis_tdata[47:32]}) - signed'({1'b0, s_axis_tdata[15:0]});
            dy     <= signed'({1'b0, s_axis_tdata[63:48]}) - signed'({1'b0, s_axis_tdata[31:16]});
            cvx    <= s_axis_tdata[79:64];
            cvy    <= s_axis_tdata[95:80];
            noise  <= s_axis_tdata[111:96];
            last   <= s_axis_tlast;
            state  <= S_DX;
          end
        end
        S_DX: begin
          prod  <= mul_a * mul_b;
          state <= S_DY;
        end
        S_DY: begin
          d2    <= {1'b0, prod[31:0]};
          prod  <= mul_a * mul_b;
          state <= S_R2;
        end
        S_R2: begin
          d2    <= d2 + {1'b0, prod[31:0]};
          prod  <= mul_a * mul_b;
          state <= S_ACC;
        end
        S_ACC: begin
          if (d2 <= {1'b0, prod[31:0]} && count < CW'(MAX_NEIGHBOURS)) begin
            if (sx_add[SUM_W] != sx_add[SUM_W-1])
              sum_vx <= sx_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            else
              sum_vx <= sx_add[SUM_W-1:0];
            if (sy_add[SUM_W] != sy_add[SUM_W-1])
              sum_vy <= sy_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            else
              sum_vy <= sy_add[SUM_W-1:0];
            count <= count + 1'b1;
          end
          state <= last ? S_NOISE : S_IDLE;
        end
        S_NOISE: begin
          prod     <= mul_a * mul_b;
          zero_sum <= (sum_vx == '0) && (sum_vy == '0);
          if (sum_vx[SUM_W-1] && !sum_vy[SUM_W-1]) begin
            cx <= sye;
            cy <= -sxe;
            cz <= {2'b00, 32'h4000_0000};
          end else if (sum_vx[SUM_W-1]) begin
            cx <= -sye;
            cy <= sxe;
            cz <= {2'b00, 32'hC000_0000};
          end else begin
            cx <= sxe;
            cy <= sye;
            cz <= '0;
          end
          count_out <= (count_ext > CXW'(511)) ? 9'd511 : count_ext[CNT_OW-1:0];
          sum_vx    <= '0;
          sum_vy    <= '0;
          count     <= '0;
          step      <= '0;
          state     <= S_VEC;
        end
        S_VEC: begin
          cx   <= nx;
          cy   <= ny;
          cz   <= nz;
          step <= step + 1'b1;
          if (step == STEP_W'(STEPS_USED - 1)) state <= S_HEAD;
        end
        S_HEAD: begin
          heading <= head_vec + prod[31:16];
          prod    <= mul_a * mul_b;
          state   <= S_LROT;
        end
        S_LROT: begin
          cx <= {3'b000, prod[44:14]};
          cy <= '0;
          if (zh > QUARTER_TURN) begin
            cz   <= zh - HALF_TURN;
            flip <= 1'b1;
          end else if (zh < -QUARTER_TURN) begin
            cz   <= zh + HALF_TURN;
            flip <= 1'b1;
          end else begin
            cz   <= zh;
            flip <= 1'b0;
          end
          step  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          cx   <= nx;
          cy   <= ny;
          cz   <= nz;
          step <= step + 1'b1;
          if (step == STEP_W'(STEPS_USED - 1)) state <= S_FIN;
        end
        S_FIN: begin
          vx    <= round_sat(cx, flip);
          vy    <= round_sat(cy, flip);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {7'd0, count_out, heading, vy, vx,
                              move_wrap(self_y, vy, arena_h),
                              move_wrap(self_x, vx, arena_w)};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/fhu_cordic_step.sv */
// one shift-add cordic iteration, shared by vectoring (atan2) and rotation
// depends on fhu_pkg for widths, the control struct and the arctangent table
module fhu_cordic_step (
  input  fhu_pkg::cordic_ctl_t                ctl,
  input  logic signed [fhu_pkg::DP_W-1:0]     x,
  input  logic signed [fhu_pkg::DP_W-1:0]     y,
  input  logic signed [fhu_pkg::DP_W-1:0]     z,
  output logic signed [fhu_pkg::DP_W-1:0]     nx,
  output logic signed [fhu_pkg::DP_W-1:0]     ny,
  output logic signed [fhu_pkg::DP_W-1:0]     nz
);
  import fhu_pkg::*;

  logic signed [DP_W-1:0] xs;
  logic signed [DP_W-1:0] ys;
  logic signed [DP_W-1:0] a;
  logic                   dir;

  assign xs  = x >>> ctl.step;
  assign ys  = y >>> ctl.step;
  assign a   = signed'({2'b00, atan_angle(ctl.step)});
  // vectoring drives y to zero, rotation drives z to zero
  assign dir = ctl.vectoring ? ~y[DP_W-1] : ~z[DP_W-1];

  always_comb begin
    if (ctl.vectoring == dir) begin
      nx = x + ys;
      ny = y - xs;
      nz = z + a;
    end else begin
      nx = x - ys;
      ny = y + xs;
      nz = z - a;
    end
  end

endmodule
